@@ rtl/lineage_pair_merge_enumerator_assert.svh @@
// Assertion macros used by the lineage pair merge enumerator controller
`ifndef LINEAGE_PAIR_MERGE_ENUMERATOR_ASSERT_SVH
`define LINEAGE_PAIR_MERGE_ENUMERATOR_ASSERT_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define LPME_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define LPME_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/lpme_pkg.sv @@
// Shared constants and controller/datapath interface types for the pair merge enumerator
package lpme_pkg;

  localparam int MAX_LIN     = 8;
  localparam int MASK_W      = 32;
  localparam int IDX_W       = $clog2(MAX_LIN);
  localparam int CNT_W       = $clog2(MAX_LIN + 1);
  localparam int OUT_SLOTS   = MAX_LIN - 1;
  localparam int IN_CNT_W    = 4;
  localparam int OUT_CNT_W   = 3;
  localparam int IN_TDATA_W  = ((MAX_LIN * MASK_W + IN_CNT_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((OUT_SLOTS * MASK_W + OUT_CNT_W + 7) / 8) * 8;

  typedef logic [MASK_W-1:0] mask_t;

  typedef struct packed {
    logic             load;
    logic             issue;
    logic             last;
    logic [IDX_W-1:0] pi;
    logic [IDX_W-1:0] pj;
    logic [CNT_W-1:0] cnt;
  } lpme_cmd_t;

  typedef struct packed {
    logic advance;
  } lpme_sts_t;

endpackage

@@ rtl/lpme_ctrl.sv @@
// Controller: accepts requests and walks the pair indices i-major, j ascending
module lpme_ctrl
  import lpme_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [IN_CNT_W-1:0] in_lineage_count,
  input  lpme_sts_t           sts,
  output lpme_cmd_t           cmd
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_t;

  state_t           state_r, state_nxt;
  logic [IDX_W-1:0] i_r, i_nxt;
  logic [IDX_W-1:0] j_r, j_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0] sat_cnt;
  logic             accept;
  logic             last_pair;
  logic             j_end;

  assign in_tready = (state_r == ST_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign sat_cnt   = (in_lineage_count > IN_CNT_W'(MAX_LIN)) ? CNT_W'(MAX_LIN)
                                                             : CNT_W'(in_lineage_count);
  assign j_end     = (CNT_W'(j_r) == cnt_r - CNT_W'(1));
  assign last_pair = j_end && (CNT_W'(i_r) == cnt_r - CNT_W'(2));

  always_comb begin
    state_nxt = state_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          cnt_nxt = sat_cnt;
          i_nxt   = '0;
          j_nxt   = IDX_W'(1);
          if (sat_cnt >= CNT_W'(2)) begin
            state_nxt = ST_RUN;
          end
        end
      end
      ST_RUN: begin
        if (sts.advance) begin
          if (last_pair) begin
            state_nxt = ST_IDLE;
          end else if (j_end) begin
            i_nxt = i_r + IDX_W'(1);
            j_nxt = i_r + IDX_W'(2);
          end else begin
            j_nxt = j_r + IDX_W'(1);
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      i_r     <= '0;
      j_r     <= '0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    cmd.load  = accept;
    cmd.issue = (state_r == ST_RUN) && sts.advance;
    cmd.last  = last_pair;
    cmd.pi    = i_r;
    cmd.pj    = j_r;
    cmd.cnt   = cnt_r;
  end

`include "lineage_pair_merge_enumerator_assert.svh"

  `LPME_ASSERT_NOW(a_pair_order, state_r == ST_RUN, j_r > i_r, "pair index j not above i")
  `LPME_ASSERT_NOW(a_run_count, state_r == ST_RUN, cnt_r >= CNT_W'(2), "run with count below two")
  `LPME_ASSERT_NEXT(a_last_ends, cmd.issue && cmd.last, state_r == ST_IDLE, "run did not end")
  `LPME_ASSERT_NOW(a_j_in_range, state_r == ST_RUN, CNT_W'(j_r) < cnt_r, "pair index j past count")

endmodule

@@ rtl/lpme_datapath.sv @@
// Datapath: mask store, merged lane stage, rank sort and output register
module lpme_datapath
  import lpme_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  lpme_cmd_t            cmd,
  output lpme_sts_t            sts,
  input  mask_t                in_mask [MAX_LIN],
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output mask_t                out_merged [OUT_SLOTS],
  output logic [OUT_CNT_W-1:0] out_count,
  output logic                 out_last
);

  mask_t                masks_r [MAX_LIN];
  mask_t                lane_r  [MAX_LIN];
  logic [MAX_LIN-1:0]   lv_r;
  logic                 s1_valid_r;
  logic                 s1_last_r;
  logic [OUT_CNT_W-1:0] s1_cnt_r;
  mask_t                merged_r [OUT_SLOTS];
  logic [OUT_CNT_W-1:0] ocnt_r;
  logic                 olast_r;
  logic                 ovalid_r;
  logic                 advance;
  logic [IDX_W-1:0]     rank [MAX_LIN];
  mask_t                slot [OUT_SLOTS];

  assign advance     = !ovalid_r || out_tready;
  assign sts.advance = advance;

  // hold the request's masks for the whole run
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      for (int k = 0; k < MAX_LIN; k++) begin
        masks_r[k] <= in_mask[k];
      end
    end
  end

  // build the lanes of one pair: OR j into i, drop j and slots past the count
  always_ff @(posedge clk) begin
    if (advance && cmd.issue) begin
      for (int k = 0; k < MAX_LIN; k++) begin
        lane_r[k] <= masks_r[k] | ((IDX_W'(k) == cmd.pi) ? masks_r[cmd.pj] : '0);
        lv_r[k]   <= (CNT_W'(k) < cmd.cnt) && (IDX_W'(k) != cmd.pj);
      end
      s1_last_r <= cmd.last;
      s1_cnt_r  <= OUT_CNT_W'(cmd.cnt - CNT_W'(1));
    end
  end

  always_comb begin
    for (int k = 0; k < MAX_LIN; k++) begin
      rank[k] = '0;
      for (int l = 0; l < MAX_LIN; l++) begin
        if (l != k && lv_r[l] &&
            (lane_r[l] < lane_r[k] || (lane_r[l] == lane_r[k] && l < k))) begin
          rank[k] = rank[k] + IDX_W'(1);
        end
      end
    end
    for (int p = 0; p < OUT_SLOTS; p++) begin
      slot[p] = '0;
      for (int k = 0; k < MAX_LIN; k++) begin
        if (lv_r[k] && rank[k] == IDX_W'(p)) begin
          slot[p] = slot[p] | lane_r[k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid_r) begin
      for (int p = 0; p < OUT_SLOTS; p++) begin
        merged_r[p] <= slot[p];
      end
      ocnt_r  <= s1_cnt_r;
      olast_r <= s1_last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      ovalid_r   <= 1'b0;
    end else if (advance) begin
      s1_valid_r <= cmd.issue;
      ovalid_r   <= s1_valid_r;
    end
  end

  assign out_tvalid = ovalid_r;
  assign out_count  = ocnt_r;
  assign out_last   = olast_r;
  always_comb begin
    for (int p = 0; p < OUT_SLOTS; p++) begin
      out_merged[p] = merged_r[p];
    end
  end

endmodule

@@ rtl/lineage_pair_merge_enumerator.sv @@
// Top level of the lineage pair merge enumerator
//
// Input channel in_*: one request per lineage state, eight masks and a count.
// Output channel out_*: one item per pair (i, j), i < j, i-major with j
// ascending; mask i is ORed with mask j, mask j dropped, and the remaining
// count-1 masks are given in ascending order, unused slots zero. out_tlast
// marks the final pair of a request. A count below two yields no output;
// a count above eight is taken as eight.
// After issue, each pair passes the lane register and then the output register.
// Throughput: one pair per cycle while the receiver does not stall, and a
// request holds the block until the controller has issued its last pair.
// in_tready is high only between runs.
// The last pairs of a run drain while the next request is taken.
// Reset (synchronous, rst_n low) empties the pipeline and returns to idle.
// When the receiver stalls, the output register and the pipeline behind it
// hold, and pair issue pauses until out_tready returns.
module lineage_pair_merge_enumerator
  import lpme_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // mask_0 .. mask_7 (32 bits each), lineage_count (4 bits), zero pad
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // merged_0 .. merged_6 (32 bits each), merged_count (3 bits), zero pad
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic                   out_tlast
);

  lpme_cmd_t            cmd;
  lpme_sts_t            sts;
  mask_t                in_mask [MAX_LIN];
  mask_t                merged [OUT_SLOTS];
  logic [OUT_CNT_W-1:0] merged_count;
  logic [IN_CNT_W-1:0]  lineage_count;

  always_comb begin
    for (int k = 0; k < MAX_LIN; k++) begin
      in_mask[k] = in_tdata[k*MASK_W +: MASK_W];
    end
  end
  assign lineage_count = in_tdata[MAX_LIN*MASK_W +: IN_CNT_W];

  lpme_ctrl u_ctrl (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_tvalid        (in_tvalid),
    .in_tready        (in_tready),
    .in_lineage_count (lineage_count),
    .sts              (sts),
    .cmd              (cmd)
  );

  lpme_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_mask    (in_mask),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_merged (merged),
    .out_count  (merged_count),
    .out_last   (out_tlast)
  );

  always_comb begin
    out_tdata = '0;
    for (int p = 0; p < OUT_SLOTS; p++) begin
      out_tdata[p*MASK_W +: MASK_W] = merged[p];
    end
    out_tdata[OUT_SLOTS*MASK_W +: OUT_CNT_W] = merged_count;
  end

endmodule
